// File: rtl/core/sgpb_pkg.sv
// shared types and constants for the sky gradient pixel blend
// no dependencies; imported by every module in rtl/core
package sgpb_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int FRACTION_BITS = 16;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = 13;
   localparam int CFG_W   = 13;
   localparam int CMP_W   = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
   localparam int FRAC_W  = FRACTION_BITS + 1;
   localparam int STEP_W  = 17;
   localparam int DIFF_W  = 9;
   localparam int PROD_W  = DIFF_W + FRAC_W + 1;
   localparam int ACC_W   = PROD_W + 1;

   localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1) << FRACTION_BITS;
   localparam logic [FRAC_W-1:0] FRAC_ZERO = '0;

   localparam int QUEUE_DEPTH = 2;  // power of two
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = QPTR_W + 1;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_FILL_MODE   = 3'd0;
   localparam logic [2:0] REG_SKY_COLOR   = 3'd1;
   localparam logic [2:0] REG_IMAGE_WIDTH = 3'd2;
   localparam logic [2:0] REG_BAND_START  = 3'd3;
   localparam logic [2:0] REG_BAND_END    = 3'd4;
   localparam logic [2:0] REG_FADE_DIR    = 3'd5;
   localparam logic [2:0] REG_FRAC_STEP   = 3'd6;

   // fill modes
   localparam logic [1:0] FILL_PASS     = 2'd0;
   localparam logic [1:0] FILL_SKY      = 2'd1;
   localparam logic [1:0] FILL_GRADIENT = 2'd2;

   typedef enum logic [1:0] {
      CLASS_PASS,
      CLASS_SKY,
      CLASS_BLEND
   } pixel_class_type;

   typedef struct packed {
      logic       frame_start;
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
   } req_payload_type;

   typedef struct packed {
      logic       out_frame_start;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]        fill_mode;
      logic [23:0]       sky_color;
      logic [CFG_W-1:0]  image_width;
      logic [CFG_W-1:0]  band_start_row;
      logic [CFG_W-1:0]  band_end_row;
      logic              fade_toward_image;
      logic [STEP_W-1:0] fraction_step;
   } cfg_type;

   // one classified pixel between front and back
   typedef struct packed {
      req_payload_type   pixel;
      pixel_class_type   pclass;
      logic [FRAC_W-1:0] frac;
   } work_item_type;

   // queue status toward the front
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/core/sgpb_front.sv
// front end: column/row counters, blend fraction, pixel classification
// depends on sgpb_pkg
module sgpb_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  sgpb_pkg::req_payload_type req_payload,
   input  sgpb_pkg::cfg_type       cfg,
   output sgpb_pkg::work_item_type item
);
   import sgpb_pkg::*;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;

   logic [COL_W-1:0]  col_cur;
   logic [ROW_W-1:0]  row_cur;
   logic [FRAC_W-1:0] frac_cur;
   logic [CMP_W-1:0]  width_eff;
   logic [CMP_W-1:0]  col_plus;
   logic              last_col;
   logic              rising;
   logic              before_band;
   logic              in_band;
   logic [FRAC_W:0]   frac_sum;
   logic [FRAC_W-1:0] frac_step;
   logic [FRAC_W-1:0] frac_upd;
   pixel_class_type   pclass;

   always_comb begin
      rising   = cfg.fade_toward_image;
      col_cur  = req_payload.frame_start ? '0 : col_ff;
      row_cur  = req_payload.frame_start ? '0 : row_ff;

      // band start reloads the fraction on its first pixel
      if (col_cur == '0 && row_cur == ROW_W'(cfg.band_start_row)) begin
         frac_cur = rising ? FRAC_ZERO : FRAC_ONE;
      end else begin
         frac_cur = frac_ff;
      end

      before_band = row_cur < ROW_W'(cfg.band_start_row);
      in_band     = !before_band && (row_cur < ROW_W'(cfg.band_end_row));

      priority if (cfg.fill_mode == FILL_SKY) begin
         pclass = CLASS_SKY;
      end else if (cfg.fill_mode == FILL_GRADIENT) begin
         if (before_band) begin
            pclass = rising ? CLASS_SKY : CLASS_PASS;
         end else if (in_band) begin
            pclass = CLASS_BLEND;
         end else begin
            pclass = rising ? CLASS_PASS : CLASS_SKY;
         end
      end else begin
         pclass = CLASS_PASS;
      end

      // clamp row length to [1, MAX_WIDTH]
      if (cfg.image_width == '0) begin
         width_eff = CMP_W'(1);
      end else if (CMP_W'(cfg.image_width) > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = CMP_W'(cfg.image_width);
      end
      col_plus = CMP_W'(col_cur) + CMP_W'(1);
      last_col = col_plus >= width_eff;

      // saturating step, up or down
      frac_step = FRAC_W'(cfg.fraction_step);
      frac_sum  = (FRAC_W + 1)'(frac_cur) + (FRAC_W + 1)'(frac_step);
      if (rising) begin
         frac_upd = (frac_sum > (FRAC_W + 1)'(FRAC_ONE)) ? FRAC_ONE : frac_sum[FRAC_W-1:0];
      end else begin
         frac_upd = (frac_cur > frac_step) ? frac_cur - frac_step : FRAC_ZERO;
      end

      col_in  = col_ff;
      row_in  = row_ff;
      frac_in = frac_ff;
      if (accept) begin
         if (last_col) begin
            col_in  = '0;
            row_in  = row_cur + ROW_W'(1);
            frac_in = in_band ? frac_upd : frac_cur;
         end else begin
            col_in  = col_plus[COL_W-1:0];
            row_in  = row_cur;
            frac_in = frac_cur;
         end
      end

      item.pixel  = req_payload;
      item.pclass = pclass;
      item.frac   = (frac_cur > FRAC_ONE) ? FRAC_ONE : frac_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         frac_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         frac_ff <= frac_in;
      end
   end

   a_frac_bounded : assert property (@(posedge clock) disable iff (reset)
      frac_ff <= FRAC_ONE)
      else $error("blend fraction above one");

   a_row_wrap : assert property (@(posedge clock) disable iff (reset)
      accept && last_col |=> col_ff == '0)
      else $error("column did not restart after last pixel of row");

endmodule

// File: rtl/core/sgpb_queue.sv
// short queue of classified pixels between front and back
// depends on sgpb_pkg
module sgpb_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sgpb_pkg::work_item_type   push_item,
   input  logic                      pop,
   output sgpb_pkg::work_item_type   head_item,
   output sgpb_pkg::queue_status_type status
);
   import sgpb_pkg::*;

   work_item_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
      status.empty = count_ff == '0;
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
      head_item = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_count_push : assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue count missed a push");

endmodule

// File: rtl/core/sgpb_back.sv
// back end: two-stage blend datapath with result register
// depends on sgpb_pkg
module sgpb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  sgpb_pkg::queue_status_type q_status,
   input  sgpb_pkg::work_item_type   q_item,
   output logic                      q_pop,
   input  logic [23:0]               sky_color,
   output sgpb_pkg::rsp_payload_type rsp_payload,
   output logic                      empty,
   input  logic                      pop
);
   import sgpb_pkg::*;

   // stage 1: per-channel (pixel - sky) * fraction
   logic                             s1_valid_ff, s1_valid_in;
   logic                             s1_fs_ff;
   pixel_class_type                  s1_class_ff;
   logic [2:0][7:0]                  s1_pix_ff;
   logic signed [2:0][PROD_W-1:0]    s1_prod_ff;
   logic signed [2:0][PROD_W-1:0]    prod_in;

   // stage 2: result register
   logic                             s2_valid_ff, s2_valid_in;
   rsp_payload_type                  s2_ff, s2_in;

   logic            s2_free;
   logic            s1_adv;
   logic            s1_load;
   logic [2:0][7:0] pix_ch;
   logic [2:0][7:0] sky_ch;
   logic [2:0][7:0] out_ch;
   logic signed [DIFF_W-1:0] diff;
   logic signed [FRAC_W:0]   frac_s;
   logic signed [ACC_W-1:0]  acc;

   always_comb begin
      s2_free = !s2_valid_ff || pop;
      s1_adv  = s1_valid_ff && s2_free;
      s1_load = !q_status.empty && (!s1_valid_ff || s1_adv);
      q_pop   = s1_load;

      s1_valid_in = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s2_valid_in = s1_adv ? 1'b1 : (pop ? 1'b0 : s2_valid_ff);

      pix_ch = {q_item.pixel.pixel_red, q_item.pixel.pixel_green, q_item.pixel.pixel_blue};
      sky_ch = {sky_color[23:16], sky_color[15:8], sky_color[7:0]};
      frac_s = $signed({1'b0, q_item.frac});
      for (int c = 0; c < 3; c++) begin
         diff       = $signed({1'b0, pix_ch[c]}) - $signed({1'b0, sky_ch[c]});
         prod_in[c] = PROD_W'(diff * frac_s);
      end

      // sky*one + (pixel-sky)*f + half, rounded down to 8 bits
      for (int c = 0; c < 3; c++) begin
         acc = $signed(ACC_W'({sky_ch[c], {FRACTION_BITS{1'b0}}}))
             + ACC_W'(s1_prod_ff[c])
             + $signed(ACC_W'(FRAC_ONE >> 1));
         unique case (s1_class_ff)
            CLASS_SKY:   out_ch[c] = sky_ch[c];
            CLASS_BLEND: out_ch[c] = acc[FRACTION_BITS +: 8];
            default:     out_ch[c] = s1_pix_ff[c];
         endcase
      end

      s2_in.out_frame_start = s1_fs_ff;
      s2_in.out_red         = out_ch[2];
      s2_in.out_green       = out_ch[1];
      s2_in.out_blue        = out_ch[0];

      rsp_payload = s2_ff;
      empty       = !s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_fs_ff    <= q_item.pixel.frame_start;
         s1_class_ff <= q_item.pclass;
         s1_pix_ff   <= pix_ch;
         s1_prod_ff  <= prod_in;
      end
      if (s1_adv) begin
         s2_ff <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

endmodule

// File: rtl/core/sky_gradient_pixel_blend.sv
// top level of the sky gradient pixel blend: register file and wiring
// depends on sgpb_pkg, sgpb_front, sgpb_queue, sgpb_back
//
// usage
// - input channel: raise push with a pixel on req_payload; it transfers at an
//   edge where push is high and full is low. frame_start marks the first pixel
//   of an image and restarts the column and row counters
// - result channel: while empty is low the oldest result sits on rsp_payload;
//   it transfers at an edge where pop is high. one result per pixel, in order
// - register port: writes take a setup then an access phase, pready tied high, reads
//   return the stored value. change registers only with the pipe drained
// - path: a taken pixel passes the queue, stage 1 and then the result register
// - throughput: one pixel per cycle while pop drains results, set by the counter
//   and fraction update in the front end and the two-stage multiply/add back end
// - when pop is held low results pile up in the result register, the stage
//   behind it and the two-entry queue; full rises once those are occupied
// - reset clears counters, fraction, pipe valid flags and all registers to
//   their defaults (image_width 1, fade_toward_image 1, others 0)
module sky_gradient_pixel_blend (
   input  logic                          clock,
   input  logic                          reset,
   // pixel input
   input  logic                          push,
   output logic                          full,
   input  sgpb_pkg::req_payload_type     req_payload,
   // result output
   output logic                          empty,
   input  logic                          pop,
   output sgpb_pkg::rsp_payload_type     rsp_payload,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sgpb_pkg::ADDR_W-1:0]   paddr,
   input  logic [sgpb_pkg::DATA_W-1:0]   pwdata,
   output logic [sgpb_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import sgpb_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             csr_write;
   logic [2:0]       reg_index;
   logic             accept;
   work_item_type    front_item;
   work_item_type    head_item;
   queue_status_type q_status;
   logic             q_pop;

   // register file
   always_comb begin
      pready    = 1'b1;
      reg_index = paddr[ADDR_W-1:2];
      csr_write = psel && penable && pwrite && pready;
      cfg_in    = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_FILL_MODE:   cfg_in.fill_mode         = pwdata[1:0];
            REG_SKY_COLOR:   cfg_in.sky_color         = pwdata[23:0];
            REG_IMAGE_WIDTH: cfg_in.image_width       = pwdata[CFG_W-1:0];
            REG_BAND_START:  cfg_in.band_start_row    = pwdata[CFG_W-1:0];
            REG_BAND_END:    cfg_in.band_end_row      = pwdata[CFG_W-1:0];
            REG_FADE_DIR:    cfg_in.fade_toward_image = pwdata[0];
            REG_FRAC_STEP:   cfg_in.fraction_step     = pwdata[STEP_W-1:0];
            default:         cfg_in = cfg_ff;  // unmapped address, write dropped
         endcase
      end

      unique case (reg_index)
         REG_FILL_MODE:   prdata = DATA_W'(cfg_ff.fill_mode);
         REG_SKY_COLOR:   prdata = DATA_W'(cfg_ff.sky_color);
         REG_IMAGE_WIDTH: prdata = DATA_W'(cfg_ff.image_width);
         REG_BAND_START:  prdata = DATA_W'(cfg_ff.band_start_row);
         REG_BAND_END:    prdata = DATA_W'(cfg_ff.band_end_row);
         REG_FADE_DIR:    prdata = DATA_W'(cfg_ff.fade_toward_image);
         REG_FRAC_STEP:   prdata = DATA_W'(cfg_ff.fraction_step);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fill_mode         <= FILL_PASS;
         cfg_ff.sky_color         <= '0;
         cfg_ff.image_width       <= CFG_W'(1);
         cfg_ff.band_start_row    <= '0;
         cfg_ff.band_end_row      <= '0;
         cfg_ff.fade_toward_image <= 1'b1;
         cfg_ff.fraction_step     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input transfer goes straight into the queue
   assign full   = q_status.full;
   assign accept = push && !q_status.full;

   sgpb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .item        (front_item)
   );

   sgpb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   sgpb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_item      (head_item),
      .q_pop       (q_pop),
      .sky_color   (cfg_ff.sky_color),
      .rsp_payload (rsp_payload),
      .empty       (empty),
      .pop         (pop)
   );

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("back end pulled from an empty queue");

endmodule

// File: test/sky_gradient_pixel_blend_tb.sv
// self-checking testbench for the sky gradient pixel blend top level
// depends on sgpb_pkg and sky_gradient_pixel_blend; carries its own pixel predictor
module sky_gradient_pixel_blend_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sgpb_pkg::*;

   localparam int         HALF_PERIOD    = 5;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         HOLD_CYCLES    = 60;
   localparam int         SETTLE_CYCLES  = 4;
   localparam int         RANDOM_PIXELS  = 680;
   localparam int         MAX_REPORTS    = 40;
   localparam logic [1:0] FILL_UNUSED    = 2'd3;  // no named mode, acts as pass

   typedef enum {POP_FREE, POP_CHOPPY, POP_SLOW} pop_pattern_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             push = 1'b0;
   logic             full;
   req_payload_type  req_payload = '0;
   logic             empty;
   logic             pop = 1'b0;
   rsp_payload_type  rsp_payload;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic             pready;

   // register shadow, starts at the documented reset values
   cfg_type cfg = '{fill_mode: FILL_PASS, sky_color: 24'h0, image_width: CFG_W'(1),
                    band_start_row: '0, band_end_row: '0, fade_toward_image: 1'b1,
                    fraction_step: '0};

   // predictor state: raster position and blend fraction
   logic [11:0]       col_count  = '0;
   logic [ROW_W-1:0]  row_count  = '0;
   logic [FRAC_W-1:0] blend_frac = '0;

   rsp_payload_type predicted_pixels[$];
   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  burst_left     = 0;
   bit  gaps_enabled   = 1'b1;
   bit  hold_request   = 1'b0;

   sky_gradient_pixel_blend u_dut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // pixel predictor
   // ---------------------------------------------------------------------

   // rounded mix of pixel and sky with fraction f weighting the pixel
   function automatic logic [7:0] blend_channel(input logic [7:0] pix, input logic [7:0] sky,
                                                input logic [FRAC_W-1:0] f);
      longint unsigned acc;
      acc = longint'(pix) * longint'(f) + longint'(sky) * (longint'(FRAC_ONE) - longint'(f))
            + (longint'(FRAC_ONE) >> 1);
      return acc[FRACTION_BITS +: 8];
   endfunction

   function automatic rsp_payload_type predict_pixel(input req_payload_type px);
      rsp_payload_type  res;
      logic [7:0]       sky_r, sky_g, sky_b;
      int unsigned      width;
      bit               rising, in_band, use_sky;
      longint unsigned  raised;
      sky_r   = cfg.sky_color[23:16];
      sky_g   = cfg.sky_color[15:8];
      sky_b   = cfg.sky_color[7:0];
      rising  = cfg.fade_toward_image;
      use_sky = 1'b0;
      // frame start restarts the raster before this pixel is classified
      if (px.frame_start) begin
         col_count = '0;
         row_count = '0;
      end
      in_band = (row_count >= cfg.band_start_row) && (row_count < cfg.band_end_row);
      width = cfg.image_width;
      if (width == 0) width = 1;
      if (width > MAX_WIDTH) width = MAX_WIDTH;
      // fraction reload on the first pixel of the band's first row
      if (col_count == 0 && row_count == cfg.band_start_row)
         blend_frac = rising ? FRAC_ZERO : FRAC_ONE;

      res.out_frame_start = px.frame_start;
      res.out_red         = px.pixel_red;
      res.out_green       = px.pixel_green;
      res.out_blue        = px.pixel_blue;
      case (cfg.fill_mode)
         FILL_SKY: use_sky = 1'b1;
         FILL_GRADIENT: begin
            if (row_count < cfg.band_start_row) begin
               use_sky = rising;
            end else if (row_count < cfg.band_end_row) begin
               res.out_red   = blend_channel(px.pixel_red, sky_r, blend_frac);
               res.out_green = blend_channel(px.pixel_green, sky_g, blend_frac);
               res.out_blue  = blend_channel(px.pixel_blue, sky_b, blend_frac);
            end else begin
               use_sky = !rising;
            end
         end
         default: ;
      endcase
      if (use_sky) begin
         res.out_red   = sky_r;
         res.out_green = sky_g;
         res.out_blue  = sky_b;
      end

      // advance raster; fraction steps once at the end of each band row
      if (int'(col_count) + 1 >= width) begin
         col_count = '0;
         if (in_band) begin
            if (rising) begin
               raised = longint'(blend_frac) + longint'(cfg.fraction_step);
               blend_frac = (raised > longint'(FRAC_ONE)) ? FRAC_ONE : raised[FRAC_W-1:0];
            end else begin
               blend_frac = (blend_frac > cfg.fraction_step) ?
                            blend_frac - cfg.fraction_step : FRAC_ZERO;
            end
         end
         row_count = row_count + 1'b1;  // wraps at 8192 rows
      end else begin
         col_count = col_count + 1'b1;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // register port: every task starts and ends at a falling edge
   // ---------------------------------------------------------------------

   task automatic apb_access(input logic [2:0] index, input bit is_write,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {index, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      // shadow follows the register at the write edge
      if (is_write) begin
         case (index)
            REG_FILL_MODE:   cfg.fill_mode         = wdata[1:0];
            REG_SKY_COLOR:   cfg.sky_color         = wdata[23:0];
            REG_IMAGE_WIDTH: cfg.image_width       = wdata[CFG_W-1:0];
            REG_BAND_START:  cfg.band_start_row    = wdata[CFG_W-1:0];
            REG_BAND_END:    cfg.band_end_row      = wdata[CFG_W-1:0];
            REG_FADE_DIR:    cfg.fade_toward_image = wdata[0];
            REG_FRAC_STEP:   cfg.fraction_step     = wdata[STEP_W-1:0];
            default: ;
         endcase
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // read back one register and compare with the shadow
   task automatic check_register(input logic [2:0] index);
      logic [31:0] got, want;
      apb_access(index, 1'b0, '0, got);
      case (index)
         REG_FILL_MODE:   want = 32'(cfg.fill_mode);
         REG_SKY_COLOR:   want = 32'(cfg.sky_color);
         REG_IMAGE_WIDTH: want = 32'(cfg.image_width);
         REG_BAND_START:  want = 32'(cfg.band_start_row);
         REG_BAND_END:    want = 32'(cfg.band_end_row);
         REG_FADE_DIR:    want = 32'(cfg.fade_toward_image);
         REG_FRAC_STEP:   want = 32'(cfg.fraction_step);
         default:         want = '0;
      endcase
      if (got !== want) report_mismatch($sformatf("register %0d readback", index), got, want);
   endtask

   // wait until every predicted pixel has come back and the pipe is quiet
   task automatic drain_pipe();
      push <= 1'b0;
      while (predicted_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_setup(input cfg_type c);
      logic [31:0] unused;
      drain_pipe();
      apb_access(REG_FILL_MODE,   1'b1, 32'(c.fill_mode), unused);
      apb_access(REG_SKY_COLOR,   1'b1, 32'(c.sky_color), unused);
      apb_access(REG_IMAGE_WIDTH, 1'b1, 32'(c.image_width), unused);
      apb_access(REG_BAND_START,  1'b1, 32'(c.band_start_row), unused);
      apb_access(REG_BAND_END,    1'b1, 32'(c.band_end_row), unused);
      apb_access(REG_FADE_DIR,    1'b1, 32'(c.fade_toward_image), unused);
      apb_access(REG_FRAC_STEP,   1'b1, 32'(c.fraction_step), unused);
      for (int idx = REG_FILL_MODE; idx <= REG_FRAC_STEP; idx++) check_register(3'(idx));
   endtask

   // ---------------------------------------------------------------------
   // pixel sender: bursts of random length with random gaps in between
   // ---------------------------------------------------------------------

   task automatic send_pixel(input req_payload_type px);
      int gap;
      if (gaps_enabled) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               push <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
      end
      push        <= 1'b1;
      req_payload <= px;
      // transfer happens at the first rising edge with full low
      do @(posedge clock); while (full);
      predicted_pixels.push_back(predict_pixel(px));
      @(negedge clock);
   endtask

   function automatic req_payload_type random_pixel(input bit fs);
      return '{frame_start: fs, pixel_red: 8'($urandom), pixel_green: 8'($urandom),
               pixel_blue: 8'($urandom)};
   endfunction

   // ---------------------------------------------------------------------
   // result side: stall pattern and checker
   // ---------------------------------------------------------------------

   initial begin : receiver
      pop_pattern_type pattern;
      int              pattern_left;
      pattern      = POP_FREE;
      pattern_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            // long hold-off so the pipe and queue fill and push stalls
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern      = pop_pattern_type'($urandom_range(0, 2));
               pattern_left = $urandom_range(10, 80);
            end
            pattern_left--;
            case (pattern)
               POP_FREE:   pop <= 1'b1;
               POP_CHOPPY: pop <= ($urandom_range(0, 3) != 0);
               default:    pop <= ($urandom_range(0, 2) == 0);
            endcase
         end
      end
   end

   // compare each popped result with the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && pop && !empty) begin
         if (predicted_pixels.size() == 0) begin
            report_mismatch("result with nothing predicted", 32'(rsp_payload), '0);
         end else begin
            want = predicted_pixels.pop_front();
            if (rsp_payload.out_frame_start !== want.out_frame_start)
               report_mismatch("out_frame_start", 32'(rsp_payload.out_frame_start),
                               32'(want.out_frame_start));
            if (rsp_payload.out_red !== want.out_red)
               report_mismatch("out_red", 32'(rsp_payload.out_red), 32'(want.out_red));
            if (rsp_payload.out_green !== want.out_green)
               report_mismatch("out_green", 32'(rsp_payload.out_green), 32'(want.out_green));
            if (rsp_payload.out_blue !== want.out_blue)
               report_mismatch("out_blue", 32'(rsp_payload.out_blue), 32'(want.out_blue));
         end
      end
   end

   // watchdog: too many cycles without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("sky_gradient_pixel_blend regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // registers must come out of reset at their documented values
   task automatic test_register_defaults();
      for (int idx = REG_FILL_MODE; idx <= REG_FRAC_STEP; idx++) check_register(3'(idx));
   endtask

   // pass through, sky fill and the unused mode at channel extremes
   task automatic test_fill_modes();
      cfg_type c;
      c = cfg;
      c.fill_mode = FILL_PASS;
      c.sky_color = 24'hA55AC3;
      apply_setup(c);
      send_pixel('{1'b1, 8'h00, 8'h00, 8'h00});
      send_pixel('{1'b0, 8'hFF, 8'hFF, 8'hFF});
      c.fill_mode = FILL_SKY;
      c.sky_color = 24'hFFFFFF;
      apply_setup(c);
      send_pixel('{1'b0, 8'h00, 8'h00, 8'h00});
      send_pixel('{1'b1, 8'h12, 8'h34, 8'h56});
      c.fill_mode = FILL_UNUSED;
      c.sky_color = 24'h000000;
      apply_setup(c);
      send_pixel('{1'b1, 8'hFF, 8'h00, 8'h80});
      send_pixel('{1'b0, 8'h01, 8'hFE, 8'h7F});
   endtask

   // sky above, half-way blend, then image below the band
   task automatic test_gradient_rising();
      cfg_type c;
      c = '{fill_mode: FILL_GRADIENT, sky_color: 24'hFF00FF, image_width: CFG_W'(2),
            band_start_row: CFG_W'(1), band_end_row: CFG_W'(3), fade_toward_image: 1'b1,
            fraction_step: STEP_W'(32768)};
      apply_setup(c);
      for (int i = 0; i < 8; i++)
         send_pixel('{i == 0, (i[0] ? 8'hFF : 8'h00), 8'hFF, 8'h80});
   endtask

   // falling fade with an oversize step that must saturate at zero
   task automatic test_gradient_falling();
      cfg_type c;
      c = '{fill_mode: FILL_GRADIENT, sky_color: 24'h204060, image_width: CFG_W'(2),
            band_start_row: CFG_W'(0), band_end_row: CFG_W'(2), fade_toward_image: 1'b0,
            fraction_step: STEP_W'(17'h1FFFF)};
      apply_setup(c);
      for (int i = 0; i < 6; i++) send_pixel('{i == 0, 8'hFF, 8'h00, 8'hFF});
   endtask

   // zero width acts as one with an inverted band; then an oversize width
   task automatic test_width_limits();
      cfg_type c;
      c = '{fill_mode: FILL_GRADIENT, sky_color: 24'h00FF00, image_width: '0,
            band_start_row: CFG_W'(3), band_end_row: CFG_W'(2), fade_toward_image: 1'b1,
            fraction_step: STEP_W'(65536)};
      apply_setup(c);
      for (int i = 0; i < 5; i++) send_pixel(random_pixel(i == 0));
      c.image_width       = CFG_W'(8191);
      c.band_start_row    = '0;
      c.band_end_row      = CFG_W'(1);
      c.fade_toward_image = 1'b0;
      apply_setup(c);
      for (int i = 0; i < 3; i++) send_pixel(random_pixel(i == 0));
   endtask

   // receiver holds off for a long stretch while pixels keep coming
   task automatic test_backpressure();
      cfg_type c;
      c = '{fill_mode: FILL_GRADIENT, sky_color: 24'($urandom), image_width: CFG_W'(3),
            band_start_row: CFG_W'(2), band_end_row: CFG_W'(6), fade_toward_image: 1'b1,
            fraction_step: STEP_W'(16384)};
      apply_setup(c);
      gaps_enabled = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++) send_pixel(random_pixel(i % 24 == 0));
      gaps_enabled = 1'b1;
   endtask

   function automatic cfg_type random_setup();
      cfg_type c;
      c.fill_mode = ($urandom_range(0, 9) < 7) ? FILL_GRADIENT : 2'($urandom_range(0, 3));
      c.sky_color = 24'($urandom);
      case ($urandom_range(0, 11))
         0:       c.image_width = '0;
         1:       c.image_width = CFG_W'(MAX_WIDTH);
         2:       c.image_width = CFG_W'($urandom_range(MAX_WIDTH + 1, 8191));
         default: c.image_width = CFG_W'($urandom_range(1, 6));
      endcase
      c.band_start_row = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom) :
                         CFG_W'($urandom_range(0, 4));
      c.band_end_row   = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom) :
                         CFG_W'($urandom_range(0, 7));
      c.fade_toward_image = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0:       c.fraction_step = '0;
         1:       c.fraction_step = STEP_W'(65536);
         2:       c.fraction_step = STEP_W'(17'h1FFFF);
         3:       c.fraction_step = STEP_W'($urandom);
         default: c.fraction_step = (c.band_end_row > c.band_start_row) ?
                     STEP_W'(65536 / (c.band_end_row - c.band_start_row)) : STEP_W'($urandom);
      endcase
      return c;
   endfunction

   // mostly well-formed frames with random content, some broken framing
   task automatic test_random_frames();
      cfg_type c;
      int      sent, width, rows, frame_len, count, noise;
      bit      fs;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         c = random_setup();
         apply_setup(c);
         width = (c.image_width == 0) ? 1 :
                 (c.image_width > MAX_WIDTH) ? MAX_WIDTH : int'(c.image_width);
         rows = (c.band_end_row < 8) ? int'(c.band_end_row) + 2 : 10;
         frame_len = width * rows;
         count = (frame_len > 60) ? 12 : frame_len * $urandom_range(1, 2);
         noise = $urandom_range(0, 9);
         for (int i = 0; i < count; i++) begin
            case (noise)
               0:       fs = 1'b0;                           // frame start never sent
               1:       fs = ($urandom_range(0, 7) == 0);    // frame start at random
               default: fs = (i % frame_len == 0);
            endcase
            send_pixel(random_pixel(fs));
         end
         sent += count;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_register_defaults();
      test_fill_modes();
      test_gradient_rising();
      test_gradient_falling();
      test_width_limits();
      test_backpressure();
      test_random_frames();

      drain_pipe();
      repeat (8) @(posedge clock);
      if (predicted_pixels.size() != 0)
         report_mismatch("results never returned", 32'(predicted_pixels.size()), '0);
      if (mismatch_count == 0) begin
         $display("sky_gradient_pixel_blend regression: pass");
      end else begin
         $display("sky_gradient_pixel_blend regression: fail");
      end
      $finish;
   end

endmodule
